// ===== rtl/ptsd_pkg.sv =====
// Shared types, widths and codes for the point-to-triangle squared distance pipeline.
package ptsd_pkg;

	localparam int COORD_W  = 16;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int DOT_W    = 2 * DIFF_W + 2;
	localparam int SUMW     = DOT_W + 2;
	localparam int WIDE_W   = 72;
	localparam int WFRAC    = 16;
	localparam int WEIGHT_W = WFRAC + 1;
	localparam int QUO_W    = WFRAC + 1;
	localparam int SQR_W    = 2 * COORD_W + 2;
	localparam int REGION_W = 3;
	localparam int SPLIT    = 17;

	localparam logic [WEIGHT_W-1:0] ONE_W = {1'b1, {WFRAC{1'b0}}};

	localparam logic [REGION_W-1:0] REG_INTERIOR = 3'd0;
	localparam logic [REGION_W-1:0] REG_EDGE12   = 3'd1;
	localparam logic [REGION_W-1:0] REG_CORNER2  = 3'd2;
	localparam logic [REGION_W-1:0] REG_EDGE02   = 3'd3;
	localparam logic [REGION_W-1:0] REG_CORNER0  = 3'd4;
	localparam logic [REGION_W-1:0] REG_EDGE01   = 3'd5;
	localparam logic [REGION_W-1:0] REG_CORNER1  = 3'd6;

	// weight source: zero, one, own quotient lane, one minus the other lane
	typedef enum logic [1:0] {SEL_ZERO, SEL_ONE, SEL_OWN, SEL_INV} wsel_t;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [COORD_W-1:0] point_z;
		logic [COORD_W-1:0] vert_a_x;
		logic [COORD_W-1:0] vert_a_y;
		logic [COORD_W-1:0] vert_a_z;
		logic [COORD_W-1:0] vert_b_x;
		logic [COORD_W-1:0] vert_b_y;
		logic [COORD_W-1:0] vert_b_z;
		logic [COORD_W-1:0] vert_c_x;
		logic [COORD_W-1:0] vert_c_y;
		logic [COORD_W-1:0] vert_c_z;
	} query_t;

	typedef struct packed {
		logic [SQR_W-1:0]    sqr_distance;
		logic [WEIGHT_W-1:0] weight_u;
		logic [WEIGHT_W-1:0] weight_v;
		logic [WEIGHT_W-1:0] weight_w;
		logic [REGION_W-1:0] region;
		logic                degenerate;
	} result_t;

	typedef struct packed {
		logic [2:0][DIFF_W-1:0] dv;
		logic [2:0][DIFF_W-1:0] e0;
		logic [2:0][DIFF_W-1:0] e1;
	} geo_t;

	typedef struct packed {
		logic [WIDE_W-1:0] num;
		logic [WIDE_W-1:0] den;
		logic              force_one;
		logic              force_zero;
	} lane_t;

	typedef struct packed {
		geo_t                geo;
		logic [REGION_W-1:0] region;
		logic                degen;
		wsel_t               sel_s;
		wsel_t               sel_t;
	} side_t;

endpackage

// ===== rtl/ptsd_divider.sv =====
// Two-lane pipelined restoring divider producing rounded Q1.16 weights.
module ptsd_divider import ptsd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  lane_t               lane_a,
	input  lane_t               lane_b,
	input  side_t               side_in,
	output logic                out_valid,
	output logic [WEIGHT_W-1:0] wa,
	output logic [WEIGHT_W-1:0] wb,
	output side_t               side_out
);

	typedef struct packed {
		logic [WIDE_W-1:0] rem;
		logic [WIDE_W-1:0] den;
		logic [QUO_W-1:0]  quo;
		logic              one;
		logic              zero;
	} qlane_t;

	qlane_t la_s [QUO_W+1];
	qlane_t lb_s [QUO_W+1];
	side_t  sd_s [QUO_W+1];
	logic [QUO_W:0] v_s;

	function automatic qlane_t lane_load(lane_t l);
		qlane_t r;
		r.rem  = (l.force_one || l.force_zero) ? '0 : l.num;
		r.den  = l.den;
		r.quo  = '0;
		r.one  = l.force_one;
		r.zero = l.force_zero;
		return r;
	endfunction

	function automatic qlane_t lane_step(qlane_t l);
		qlane_t r;
		logic [WIDE_W-1:0] r2;
		logic ge;
		r2 = {l.rem[WIDE_W-2:0], 1'b0};
		ge = (r2 >= l.den);
		r = l;
		r.rem = ge ? (r2 - l.den) : r2;
		r.quo = {l.quo[QUO_W-2:0], ge};
		return r;
	endfunction

	function automatic logic [WEIGHT_W-1:0] lane_round(qlane_t l);
		logic [QUO_W:0] q;
		q = {1'b0, l.quo} + {{QUO_W{1'b0}}, 1'b1};
		if (l.zero)
			return '0;
		else if (l.one)
			return ONE_W;
		else
			return q[QUO_W:1];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[QUO_W-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			la_s[0] <= lane_load(lane_a);
			lb_s[0] <= lane_load(lane_b);
			sd_s[0] <= side_in;
			for (int k = 1; k <= QUO_W; k++) begin
				la_s[k] <= lane_step(la_s[k-1]);
				lb_s[k] <= lane_step(lb_s[k-1]);
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign wa        = lane_round(la_s[QUO_W]);
	assign wb        = lane_round(lb_s[QUO_W]);
	assign side_out  = sd_s[QUO_W];

endmodule

// ===== rtl/point_triangle_sqr_distance.sv =====
// Top level: pipelined squared distance from a point to a triangle with barycentric weights.
// Takes one query per clock while query_stall is low and returns its result in order. The
// pipeline holds the two 17-step restoring divider lanes that form the weight quotients,
// the dot products, the split products of the 36-bit dot products for the determinant
// and the distance squares. While a result waits under result_stall the whole pipeline
// holds, so query_stall is raised in the same cycle.
module point_triangle_sqr_distance import ptsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  query_t  query,
	input  logic    query_valid,
	output logic    query_stall,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	localparam int DW = DIFF_W + WFRAC + 3;
	localparam int MW = DW - 1;
	localparam int HW = MW - SPLIT;
	localparam int PW = DIFF_W + WEIGHT_W + 1;

	typedef struct packed {
		geo_t            geo;
		logic [SUMW-1:0] n1;
		logic [SUMW-1:0] n6;
		logic [SUMW-1:0] den;
		logic [SUMW-1:0] t2;
		logic [SUMW-1:0] t6;
		logic [DOT_W-1:0] a00;
		logic [DOT_W-1:0] a11;
		logic [DOT_W-1:0] b0;
		logic [DOT_W-1:0] b1;
	} aux_t;

	typedef struct packed {
		logic n1p;
		logic n1ge;
		logic n6p;
		logic n6ge;
		logic t2le;
		logic t6le;
		logic b0n;
		logic b0ge;
		logic b1n;
		logic b1ge;
	} flags_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] u;
		logic [WEIGHT_W-1:0] v;
		logic [WEIGHT_W-1:0] w;
		logic [REGION_W-1:0] region;
		logic                degen;
	} tag_t;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s26, v_s27, v_s28, v_s29, v_s30, v_s31, v_s32, v_s33;

	assign adv         = !(v_s33 && result_stall);
	assign query_stall = !adv;

	// s1: edge and offset vectors
	logic [COORD_W-1:0] pc [3];
	logic [COORD_W-1:0] ac [3];
	logic [COORD_W-1:0] bc [3];
	logic [COORD_W-1:0] cc [3];
	geo_t geo_n, g_s1, g_s2;

	always_comb begin
		pc[0] = query.point_x;  pc[1] = query.point_y;  pc[2] = query.point_z;
		ac[0] = query.vert_a_x; ac[1] = query.vert_a_y; ac[2] = query.vert_a_z;
		bc[0] = query.vert_b_x; bc[1] = query.vert_b_y; bc[2] = query.vert_b_z;
		cc[0] = query.vert_c_x; cc[1] = query.vert_c_y; cc[2] = query.vert_c_z;
		for (int i = 0; i < 3; i++) begin
			geo_n.dv[i] = {ac[i][COORD_W-1], ac[i]} - {pc[i][COORD_W-1], pc[i]};
			geo_n.e0[i] = {bc[i][COORD_W-1], bc[i]} - {ac[i][COORD_W-1], ac[i]};
			geo_n.e1[i] = {cc[i][COORD_W-1], cc[i]} - {ac[i][COORD_W-1], ac[i]};
		end
	end

	// s2: component products
	logic signed [2*DIFF_W-1:0] m00_s2 [3];
	logic signed [2*DIFF_W-1:0] m01_s2 [3];
	logic signed [2*DIFF_W-1:0] m11_s2 [3];
	logic signed [2*DIFF_W-1:0] mb0_s2 [3];
	logic signed [2*DIFF_W-1:0] mb1_s2 [3];

	// s3: dot products
	logic signed [DOT_W-1:0] a00_s3, a01_s3, a11_s3, b0_s3, b1_s3;
	geo_t g_s3;

	// s4: partial products and region helpers
	logic signed [DOT_W-1:0]  mx [6];
	logic signed [DOT_W-1:0]  my [6];
	logic signed [DOT_W+17:0] pl_s4 [6];
	logic signed [DOT_W+18:0] ph_s4 [6];
	aux_t aux_n, aux_s4, aux_s5, aux_s6, aux_s7;

	always_comb begin
		mx[0] = a00_s3; my[0] = a11_s3;
		mx[1] = a01_s3; my[1] = a01_s3;
		mx[2] = a01_s3; my[2] = b1_s3;
		mx[3] = a11_s3; my[3] = b0_s3;
		mx[4] = a01_s3; my[4] = b0_s3;
		mx[5] = a00_s3; my[5] = b1_s3;
		aux_n.geo = g_s3;
		aux_n.n1  = SUMW'(a11_s3) + SUMW'(b1_s3) - SUMW'(a01_s3) - SUMW'(b0_s3);
		aux_n.n6  = SUMW'(a00_s3) + SUMW'(b0_s3) - SUMW'(a01_s3) - SUMW'(b1_s3);
		aux_n.den = SUMW'(a00_s3) - (SUMW'(a01_s3) << 1) + SUMW'(a11_s3);
		aux_n.t2  = SUMW'(a11_s3) + SUMW'(b1_s3);
		aux_n.t6  = SUMW'(a00_s3) + SUMW'(b0_s3);
		aux_n.a00 = a00_s3;
		aux_n.a11 = a11_s3;
		aux_n.b0  = b0_s3;
		aux_n.b1  = b1_s3;
	end

	// s5: full products and comparison flags
	logic signed [WIDE_W-1:0] mp_s5 [6];
	logic signed [SUMW-1:0] a00w, a11w, nb0w, nb1w;
	flags_t flg_n, flg_s5, flg_s6, flg_s7;

	always_comb begin
		a00w = SUMW'($signed(aux_s4.a00));
		a11w = SUMW'($signed(aux_s4.a11));
		nb0w = SUMW'(0) - SUMW'($signed(aux_s4.b0));
		nb1w = SUMW'(0) - SUMW'($signed(aux_s4.b1));
		flg_n.n1p  = $signed(aux_s4.n1) > 0;
		flg_n.n1ge = $signed(aux_s4.n1) >= $signed(aux_s4.den);
		flg_n.n6p  = $signed(aux_s4.n6) > 0;
		flg_n.n6ge = $signed(aux_s4.n6) >= $signed(aux_s4.den);
		flg_n.t2le = $signed(aux_s4.t2) <= 0;
		flg_n.t6le = $signed(aux_s4.t6) <= 0;
		flg_n.b0n  = aux_s4.b0[DOT_W-1];
		flg_n.b0ge = nb0w >= a00w;
		flg_n.b1n  = aux_s4.b1[DOT_W-1];
		flg_n.b1ge = nb1w >= a11w;
	end

	// s6, s7: determinant and barycentric numerators
	logic signed [WIDE_W-1:0] detr_s6, s_s6, t_s6;
	logic signed [WIDE_W-1:0] det_s7, s_s7, t_s7, st_s7;

	// s8 (divider input): region decision and quotient lane setup
	lane_t la_n, lb_n, ea, eb, ia, ib, f1, f6;
	side_t sd_n;

	always_comb begin
		ea.num        = WIDE_W'(0) - WIDE_W'($signed(aux_s7.b0));
		ea.den        = WIDE_W'($signed(aux_s7.a00));
		ea.force_zero = !flg_s7.b0n;
		ea.force_one  = flg_s7.b0n && flg_s7.b0ge;
		eb.num        = WIDE_W'(0) - WIDE_W'($signed(aux_s7.b1));
		eb.den        = WIDE_W'($signed(aux_s7.a11));
		eb.force_zero = !flg_s7.b1n;
		eb.force_one  = flg_s7.b1n && flg_s7.b1ge;
		ia.num        = s_s7;
		ia.den        = det_s7;
		ia.force_zero = 1'b0;
		ia.force_one  = s_s7 >= det_s7;
		ib.num        = t_s7;
		ib.den        = det_s7;
		ib.force_zero = 1'b0;
		ib.force_one  = t_s7 >= det_s7;
		f1.num        = WIDE_W'($signed(aux_s7.n1));
		f1.den        = WIDE_W'($signed(aux_s7.den));
		f1.force_zero = 1'b0;
		f1.force_one  = 1'b0;
		f6.num        = WIDE_W'($signed(aux_s7.n6));
		f6.den        = f1.den;
		f6.force_zero = 1'b0;
		f6.force_one  = 1'b0;

		la_n            = '0;
		la_n.force_zero = 1'b1;
		lb_n            = '0;
		lb_n.force_zero = 1'b1;
		sd_n.geo    = aux_s7.geo;
		sd_n.region = REG_INTERIOR;
		sd_n.degen  = 1'b0;
		sd_n.sel_s  = SEL_ZERO;
		sd_n.sel_t  = SEL_ZERO;

		if (st_s7 <= det_s7) begin
			if (s_s7[WIDE_W-1]) begin
				if (t_s7[WIDE_W-1]) begin
					sd_n.region = REG_CORNER0;
					if (flg_s7.b0n) begin
						la_n = ea;
						sd_n.sel_s = SEL_OWN;
					end else begin
						lb_n = eb;
						sd_n.sel_t = SEL_OWN;
					end
				end else begin
					sd_n.region = REG_EDGE02;
					lb_n = eb;
					sd_n.sel_t = SEL_OWN;
				end
			end else if (t_s7[WIDE_W-1]) begin
				sd_n.region = REG_EDGE01;
				la_n = ea;
				sd_n.sel_s = SEL_OWN;
			end else begin
				sd_n.region = REG_INTERIOR;
				if (det_s7 == '0) begin
					sd_n.degen = 1'b1;
				end else begin
					la_n = ia;
					lb_n = ib;
					sd_n.sel_s = SEL_OWN;
					sd_n.sel_t = SEL_OWN;
				end
			end
		end else if (s_s7[WIDE_W-1]) begin
			sd_n.region = REG_CORNER2;
			if (flg_s7.n1p) begin
				if (flg_s7.n1ge) begin
					sd_n.sel_s = SEL_ONE;
				end else begin
					la_n = f1;
					sd_n.sel_s = SEL_OWN;
					sd_n.sel_t = SEL_INV;
				end
			end else if (flg_s7.t2le) begin
				sd_n.sel_t = SEL_ONE;
			end else begin
				lb_n = eb;
				sd_n.sel_t = SEL_OWN;
			end
		end else if (t_s7[WIDE_W-1]) begin
			sd_n.region = REG_CORNER1;
			if (flg_s7.n6p) begin
				if (flg_s7.n6ge) begin
					sd_n.sel_t = SEL_ONE;
				end else begin
					lb_n = f6;
					sd_n.sel_t = SEL_OWN;
					sd_n.sel_s = SEL_INV;
				end
			end else if (flg_s7.t6le) begin
				sd_n.sel_s = SEL_ONE;
			end else begin
				la_n = ea;
				sd_n.sel_s = SEL_OWN;
			end
		end else begin
			sd_n.region = REG_EDGE12;
			if (!flg_s7.n1p) begin
				sd_n.sel_t = SEL_ONE;
			end else if (flg_s7.n1ge) begin
				sd_n.sel_s = SEL_ONE;
			end else begin
				la_n = f1;
				sd_n.sel_s = SEL_OWN;
				sd_n.sel_t = SEL_INV;
			end
		end
	end

	logic                div_valid;
	logic [WEIGHT_W-1:0] div_wa, div_wb;
	side_t               div_side;

	ptsd_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s7),
		.lane_a    (la_n),
		.lane_b    (lb_n),
		.side_in   (sd_n),
		.out_valid (div_valid),
		.wa        (div_wa),
		.wb        (div_wb),
		.side_out  (div_side)
	);

	// s26: weight selection
	logic [WEIGHT_W-1:0] sq_n, tq_n, sq_s26, tq_s26;
	side_t side_s26;

	always_comb begin
		case (div_side.sel_s)
			SEL_ZERO: sq_n = '0;
			SEL_ONE:  sq_n = ONE_W;
			SEL_OWN:  sq_n = div_wa;
			SEL_INV:  sq_n = ONE_W - div_wb;
			default:  sq_n = '0;
		endcase
		case (div_side.sel_t)
			SEL_ZERO: tq_n = '0;
			SEL_ONE:  tq_n = ONE_W;
			SEL_OWN:  tq_n = div_wb;
			SEL_INV:  tq_n = ONE_W - div_wa;
			default:  tq_n = '0;
		endcase
	end

	// s27: third weight and closest point offsets
	logic [WEIGHT_W:0] wsum;
	tag_t tag_n, tag_s27, tag_s28, tag_s29, tag_s30, tag_s31, tag_s32;
	logic signed [PW-1:0] ps_s27 [3];
	logic signed [PW-1:0] pt_s27 [3];
	geo_t g_s27;

	always_comb begin
		wsum = {1'b0, sq_s26} + {1'b0, tq_s26};
		tag_n.u      = (wsum >= {1'b0, ONE_W}) ? '0 : WEIGHT_W'({1'b0, ONE_W} - wsum);
		tag_n.v      = sq_s26;
		tag_n.w      = tq_s26;
		tag_n.region = side_s26.region;
		tag_n.degen  = side_s26.degen;
	end

	// s28..s33: distance vector, magnitude, squares, sum, rounding
	logic signed [DW-1:0] d_s28 [3];
	logic [MW-1:0] mag_s29 [3];
	logic [2*HW-1:0] hh_s30 [3];
	logic [2*HW-2:0] hl_s30 [3];
	logic [2*SPLIT-1:0] ll_s30 [3];
	logic [WIDE_W-1:0] sqv_s31 [3];
	logic [WIDE_W-1:0] sum_s32, rnd;
	result_t res_n, result_s33;

	always_comb begin
		rnd = sum_s32 + (WIDE_W'(1) << (2 * WFRAC - 1));
		res_n.sqr_distance = (rnd[WIDE_W-1:2*WFRAC+SQR_W] != '0) ? {SQR_W{1'b1}}
			: rnd[2*WFRAC+SQR_W-1:2*WFRAC];
		res_n.weight_u   = tag_s32.u;
		res_n.weight_v   = tag_s32.v;
		res_n.weight_w   = tag_s32.w;
		res_n.region     = tag_s32.region;
		res_n.degenerate = tag_s32.degen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
			{v_s26, v_s27, v_s28, v_s29, v_s30, v_s31, v_s32, v_s33} <= '0;
		end else if (adv) begin
			v_s1  <= query_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s26 <= div_valid;
			v_s27 <= v_s26;
			v_s28 <= v_s27;
			v_s29 <= v_s28;
			v_s30 <= v_s29;
			v_s31 <= v_s30;
			v_s32 <= v_s31;
			v_s33 <= v_s32;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s1 <= geo_n;

			for (int i = 0; i < 3; i++) begin
				m00_s2[i] <= $signed(g_s1.e0[i]) * $signed(g_s1.e0[i]);
				m01_s2[i] <= $signed(g_s1.e0[i]) * $signed(g_s1.e1[i]);
				m11_s2[i] <= $signed(g_s1.e1[i]) * $signed(g_s1.e1[i]);
				mb0_s2[i] <= $signed(g_s1.dv[i]) * $signed(g_s1.e0[i]);
				mb1_s2[i] <= $signed(g_s1.dv[i]) * $signed(g_s1.e1[i]);
			end
			g_s2 <= g_s1;

			a00_s3 <= DOT_W'(m00_s2[0]) + DOT_W'(m00_s2[1]) + DOT_W'(m00_s2[2]);
			a01_s3 <= DOT_W'(m01_s2[0]) + DOT_W'(m01_s2[1]) + DOT_W'(m01_s2[2]);
			a11_s3 <= DOT_W'(m11_s2[0]) + DOT_W'(m11_s2[1]) + DOT_W'(m11_s2[2]);
			b0_s3  <= DOT_W'(mb0_s2[0]) + DOT_W'(mb0_s2[1]) + DOT_W'(mb0_s2[2]);
			b1_s3  <= DOT_W'(mb1_s2[0]) + DOT_W'(mb1_s2[1]) + DOT_W'(mb1_s2[2]);
			g_s3   <= g_s2;

			for (int k = 0; k < 6; k++) begin
				pl_s4[k] <= mx[k] * $signed({1'b0, my[k][SPLIT-1:0]});
				ph_s4[k] <= mx[k] * $signed(my[k][DOT_W-1:SPLIT]);
			end
			aux_s4 <= aux_n;

			for (int k = 0; k < 6; k++)
				mp_s5[k] <= (WIDE_W'(ph_s4[k]) <<< SPLIT) + WIDE_W'(pl_s4[k]);
			aux_s5 <= aux_s4;
			flg_s5 <= flg_n;

			detr_s6 <= mp_s5[0] - mp_s5[1];
			s_s6    <= mp_s5[2] - mp_s5[3];
			t_s6    <= mp_s5[4] - mp_s5[5];
			aux_s6  <= aux_s5;
			flg_s6  <= flg_s5;

			det_s7 <= detr_s6[WIDE_W-1] ? -detr_s6 : detr_s6;
			st_s7  <= s_s6 + t_s6;
			s_s7   <= s_s6;
			t_s7   <= t_s6;
			aux_s7 <= aux_s6;
			flg_s7 <= flg_s6;

			sq_s26   <= sq_n;
			tq_s26   <= tq_n;
			side_s26 <= div_side;

			for (int i = 0; i < 3; i++) begin
				ps_s27[i] <= $signed({1'b0, sq_s26}) * $signed(side_s26.geo.e0[i]);
				pt_s27[i] <= $signed({1'b0, tq_s26}) * $signed(side_s26.geo.e1[i]);
			end
			g_s27   <= side_s26.geo;
			tag_s27 <= tag_n;

			for (int i = 0; i < 3; i++)
				d_s28[i] <= (DW'($signed(g_s27.dv[i])) <<< WFRAC)
					+ DW'(ps_s27[i]) + DW'(pt_s27[i]);
			tag_s28 <= tag_s27;

			for (int i = 0; i < 3; i++)
				mag_s29[i] <= MW'(d_s28[i][DW-1] ? -d_s28[i] : d_s28[i]);
			tag_s29 <= tag_s28;

			for (int i = 0; i < 3; i++) begin
				hh_s30[i] <= mag_s29[i][MW-1:SPLIT] * mag_s29[i][MW-1:SPLIT];
				hl_s30[i] <= mag_s29[i][MW-1:SPLIT] * mag_s29[i][SPLIT-1:0];
				ll_s30[i] <= mag_s29[i][SPLIT-1:0] * mag_s29[i][SPLIT-1:0];
			end
			tag_s30 <= tag_s29;

			for (int i = 0; i < 3; i++)
				sqv_s31[i] <= (WIDE_W'(hh_s30[i]) << (2 * SPLIT))
					+ (WIDE_W'(hl_s30[i]) << (SPLIT + 1)) + WIDE_W'(ll_s30[i]);
			tag_s31 <= tag_s30;

			sum_s32 <= sqv_s31[0] + sqv_s31[1] + sqv_s31[2];
			tag_s32 <= tag_s31;

			result_s33 <= res_n;
		end
	end

	assign result       = result_s33;
	assign result_valid = v_s33;

	a_degen_vertex0: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
			result.region == REG_INTERIOR && result.weight_u == ONE_W)
		else $error("degenerate result not at vertex 0");

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.weight_u != '0 |->
			(19'(result.weight_u) + 19'(result.weight_v) + 19'(result.weight_w)) == 19'(ONE_W))
		else $error("barycentric weights do not sum to one");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.weight_v <= ONE_W && result.weight_w <= ONE_W
			&& result.region <= REG_CORNER1)
		else $error("weight or region out of range");

endmodule

// ===== tb/tb_point_triangle_sqr_distance.sv =====
// Testbench for point_triangle_sqr_distance: random and directed queries checked against a wide-integer predictor.
`timescale 1ns / 1ps

module tb_point_triangle_sqr_distance;
	import ptsd_pkg::*;

	typedef logic signed [191:0] wide_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int HOLD_CYCLES    = 300;

	logic    clk;
	logic    arst_n;
	query_t  query;
	logic    query_valid;
	logic    query_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall;

	query_t  pending_q[$];
	result_t expected_q[$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	bit hold_req;
	int errors;
	int n_in;
	int n_out;
	int idle_cycles;
	int region_hits[8];
	int degen_hits;

	point_triangle_sqr_distance uut (
		.clk(clk),
		.arst_n(arst_n),
		.query(query),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.result(result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic wide_t quotient_weight(wide_t num, wide_t den);
		wide_t one;
		wide_t q;
		one = 65536;
		if (den <= 0 || num <= 0) return 0;
		if (num >= den) return one;
		q = (2 * num * one + den) / (2 * den);
		return (q > one) ? one : q;
	endfunction

	function automatic wide_t edge_weight(wide_t b, wide_t a);
		if (b >= 0) return 0;
		if (-b >= a) return 65536;
		return quotient_weight(-b, a);
	endfunction

	function automatic result_t predict_distance(query_t q);
		wide_t pt[3], va[3], vb[3], vc[3], dv[3], e0[3], e1[3];
		wide_t a00, a01, a11, b0, b1, det, s, t, denom, tmp0, tmp1, numer;
		wide_t one, sq, tq, d, sum, sqd, smax;
		result_t r;
		int i;
		one = 65536;
		pt[0] = $signed(q.point_x);  pt[1] = $signed(q.point_y);  pt[2] = $signed(q.point_z);
		va[0] = $signed(q.vert_a_x); va[1] = $signed(q.vert_a_y); va[2] = $signed(q.vert_a_z);
		vb[0] = $signed(q.vert_b_x); vb[1] = $signed(q.vert_b_y); vb[2] = $signed(q.vert_b_z);
		vc[0] = $signed(q.vert_c_x); vc[1] = $signed(q.vert_c_y); vc[2] = $signed(q.vert_c_z);
		a00 = 0; a01 = 0; a11 = 0; b0 = 0; b1 = 0;
		for (i = 0; i < 3; i++) begin
			dv[i] = va[i] - pt[i];
			e0[i] = vb[i] - va[i];
			e1[i] = vc[i] - va[i];
			a00 += e0[i] * e0[i];
			a01 += e0[i] * e1[i];
			a11 += e1[i] * e1[i];
			b0 += dv[i] * e0[i];
			b1 += dv[i] * e1[i];
		end
		det = a00 * a11 - a01 * a01;
		if (det < 0) det = -det;
		s = a01 * b1 - a11 * b0;
		t = a01 * b0 - a00 * b1;
		denom = a00 - 2 * a01 + a11;
		sq = 0;
		tq = 0;
		r = '0;
		if (s + t <= det) begin
			if (s < 0) begin
				if (t < 0) begin
					r.region = REG_CORNER0;
					if (b0 < 0) sq = edge_weight(b0, a00);
					else tq = edge_weight(b1, a11);
				end else begin
					r.region = REG_EDGE02;
					tq = edge_weight(b1, a11);
				end
			end else if (t < 0) begin
				r.region = REG_EDGE01;
				sq = edge_weight(b0, a00);
			end else begin
				r.region = REG_INTERIOR;
				if (det == 0) r.degenerate = 1'b1;
				else begin
					sq = quotient_weight(s, det);
					tq = quotient_weight(t, det);
				end
			end
		end else if (s < 0) begin
			r.region = REG_CORNER2;
			tmp0 = a01 + b0;
			tmp1 = a11 + b1;
			if (tmp1 > tmp0) begin
				numer = tmp1 - tmp0;
				if (numer >= denom) sq = one;
				else begin
					sq = quotient_weight(numer, denom);
					tq = one - sq;
				end
			end else if (tmp1 <= 0) tq = one;
			else tq = edge_weight(b1, a11);
		end else if (t < 0) begin
			r.region = REG_CORNER1;
			tmp0 = a01 + b1;
			tmp1 = a00 + b0;
			if (tmp1 > tmp0) begin
				numer = tmp1 - tmp0;
				if (numer >= denom) tq = one;
				else begin
					tq = quotient_weight(numer, denom);
					sq = one - tq;
				end
			end else if (tmp1 <= 0) sq = one;
			else sq = edge_weight(b0, a00);
		end else begin
			r.region = REG_EDGE12;
			numer = (a11 + b1) - (a01 + b0);
			if (numer <= 0) tq = one;
			else if (numer >= denom) sq = one;
			else begin
				sq = quotient_weight(numer, denom);
				tq = one - sq;
			end
		end
		sum = 0;
		for (i = 0; i < 3; i++) begin
			d = dv[i] * one + sq * e0[i] + tq * e1[i];
			sum += d * d;
		end
		sqd = (2 * sum + one * one) / (2 * one * one);
		smax = (wide_t'(1) <<< SQR_W) - 1;
		if (sqd > smax) sqd = smax;
		r.sqr_distance = sqd[SQR_W-1:0];
		r.weight_u = (sq + tq >= one) ? '0 : WEIGHT_W'(one - sq - tq);
		r.weight_v = sq[WEIGHT_W-1:0];
		r.weight_w = tq[WEIGHT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d", n_out, what, got, want);
		errors++;
	endtask

	function automatic query_t make_query(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
			logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
			logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
			logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
		return '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
	endfunction

	function automatic logic [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(2048)) - 1024);
			2: return 16'($signed($urandom_range(64)) - 32);
			default: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
				: 16'h8000 + 16'($urandom_range(3));
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		int mode;
		int kind;
		mode = $urandom_range(9) < 3 ? 0 : ($urandom_range(9) < 6 ? 1 : ($urandom_range(4) == 0 ? 3 : 2));
		q = make_query(rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode));
		kind = $urandom_range(9);
		if (kind == 0) begin
			q.vert_c_x = q.vert_b_x; q.vert_c_y = q.vert_b_y; q.vert_c_z = q.vert_b_z;
		end else if (kind == 1) begin
			// collinear: c = 2b - a
			q.vert_c_x = (q.vert_b_x << 1) - q.vert_a_x;
			q.vert_c_y = (q.vert_b_y << 1) - q.vert_a_y;
			q.vert_c_z = (q.vert_b_z << 1) - q.vert_a_z;
		end else if (kind == 2) begin
			q.point_z = q.vert_a_z;
			q.vert_b_z = q.vert_a_z;
			q.vert_c_z = q.vert_a_z;
		end
		return q;
	endfunction

	// driver: prediction is taken on each accepted query transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_valid <= 1'b0;
			query <= '0;
		end else begin
			if (query_valid && !query_stall) begin
				expected_q.push_back(predict_distance(query));
				n_in++;
			end
			if (!query_valid || !query_stall) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					query <= pending_q.pop_front();
					query_valid <= 1'b1;
				end else begin
					query_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and result-side stall
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$display("result transfer with nothing expected");
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (result.sqr_distance !== want.sqr_distance)
						report_mismatch("sqr_distance", result.sqr_distance, want.sqr_distance);
					if (result.weight_u !== want.weight_u)
						report_mismatch("weight_u", result.weight_u, want.weight_u);
					if (result.weight_v !== want.weight_v)
						report_mismatch("weight_v", result.weight_v, want.weight_v);
					if (result.weight_w !== want.weight_w)
						report_mismatch("weight_w", result.weight_w, want.weight_w);
					if (result.region !== want.region)
						report_mismatch("region", result.region, want.region);
					if (result.degenerate !== want.degenerate)
						report_mismatch("degenerate", result.degenerate, want.degenerate);
					region_hits[want.region]++;
					if (want.degenerate) degen_hits++;
				end
				n_out++;
			end
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((query_valid && !query_stall) || (result_valid && !result_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("point_triangle_sqr_distance test failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_q.size() > 0 || query_valid || expected_q.size() > 0) @(posedge clk);
	endtask

	initial begin
		query_t q;
		int ph;
		arst_n = 1'b0;
		send_idle_pct = 35;
		recv_idle_pct = 56;
		hold_req = 1'b0;
		errors = 0;
		n_in = 0;
		n_out = 0;
		idle_cycles = 0;
		degen_hits = 0;
		foreach (region_hits[i]) region_hits[i] = 0;

		// directed: extremes, degenerate shapes, each region
		pending_q.push_back('0);
		pending_q.push_back({12{16'h7fff}});
		pending_q.push_back({12{16'h8000}});
		pending_q.push_back({12{16'hffff}});
		pending_q.push_back(make_query(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000));
		pending_q.push_back(make_query(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
			16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000));
		pending_q.push_back(make_query(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
			16'h0200, 16'h0200, 16'h0200, 16'h0300, 16'h0300, 16'h0300));
		pending_q.push_back(make_query(16'h0040, 16'h0040, 16'h0100, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000));
		pending_q.push_back(make_query(16'h0100, 16'h0100, 16'h0010, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000));
		pending_q.push_back(make_query(16'hff00, 16'h0080, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000));
		pending_q.push_back(make_query(16'hff00, 16'hff00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000));
		pending_q.push_back(make_query(16'h0080, 16'hff00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000));
		pending_q.push_back(make_query(16'h0300, 16'hff00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000));
		pending_q.push_back(make_query(16'hff00, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000));
		pending_q.push_back(make_query(16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
			16'h0003, 16'h0000, 16'h0000, 16'h0000, 16'h0003, 16'h0000));
		pending_q.push_back(make_query(16'h0050, 16'h0050, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 16'h0100, 16'h0000, 16'h0200, 16'h0200, 16'h0000));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 56 : 0;
			recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 35 : 0;
			for (int k = 0; k < 380; k++) begin
				q = random_query();
				pending_q.push_back(q);
				if (k == 150 && ph != 1) begin
					hold_req = 1'b1;
				end
				if (k == 250) begin
					// sender waits out everything in flight
					wait_drained();
				end else if (pending_q.size() > 16) begin
					while (pending_q.size() > 4) @(posedge clk);
				end
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d queries, %0d results; regions 0..6: %0d %0d %0d %0d %0d %0d %0d",
			n_in, n_out, region_hits[0], region_hits[1], region_hits[2], region_hits[3],
			region_hits[4], region_hits[5], region_hits[6]);
		$display("degenerate interior cases: %0d, mismatches: %0d", degen_hits, errors);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("point_triangle_sqr_distance test passed");
		end else begin
			$display("point_triangle_sqr_distance test failed");
		end
		$finish;
	end

endmodule
